// ===== rtl/core/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg - shared definitions for the timed event queue
// Command and status codes, beat layouts and the stored entry type.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int TEQ_DEPTH = 16;

  localparam int TIME_W  = 32;
  localparam int TAG_W   = 16;
  localparam int CNT_OUT_W = 5;

  // input beat: tdata = event_time, event_tag, now (80 bits); tuser = command
  localparam int IN_TDATA_W = 80;
  localparam int IN_TUSER_W = 2;

  // result beat: tdata = released_tag, queued_count, head_present, wait_seconds
  // (54 bits, padded to 56); tuser = released_valid, release_reason, status
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 4;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REASON_DUE   = 1'b0;
  localparam logic REASON_FLUSH = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] due;
  } teq_entry_t;

endpackage

// ===== rtl/core/teq_store.sv =====
// ----------------------------------------------------------------------------
// teq_store - event entry memory
// Circular entry store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module teq_store
  import teq_pkg::*;
#(
  parameter int DEPTH = TEQ_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  teq_entry_t       wr_data,
  input  logic [AW-1:0]    rd_addr,
  output teq_entry_t       rd_data
);

  teq_entry_t mem [DEPTH];
  teq_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/timed_event_queue.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue - sorted timer queue
// Holds up to DEPTH events ordered by due time; releases due events on a
// tick and all events on a flush, one result beat per released event.
// ----------------------------------------------------------------------------
// Sequence: an insert walks the held entries from the tail down, one compare per
//   held entry at most, then shows its result beat; a releasing tick or flush
//   shows one beat per released event, reading each from the store first; any
//   other command shows its single beat.
// Throughput: one command at a time; the input is held until the last result
//   beat of a command is registered, and any result stall holds it longer; the
//   single store read port and the shared time comparator set the pace.
// Reset: synchronous, active low; empties the queue at once, no clearing pass.
// ----------------------------------------------------------------------------
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int DEPTH = TEQ_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // event_time[31:0], event_tag[47:32], now[79:48]
  input  logic [IN_TUSER_W-1:0]   in_tuser,   // command[1:0]
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // released_tag[15:0], queued_count[20:16],
                                              // head_present[21], wait_seconds[53:22], zero pad
  output logic [OUT_TUSER_W-1:0]  out_tuser,  // released_valid[0], release_reason[1], status[3:2]
  output logic                    out_tlast   // last_of_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_INS_PUT  = 3'd2;
  localparam logic [2:0] S_RESULT   = 3'd3;
  localparam logic [2:0] S_POP_TAG  = 3'd4;
  localparam logic [2:0] S_POP_EMIT = 3'd5;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // input beat fields
  logic [1:0]        in_cmd;
  logic [TIME_W-1:0] in_time;
  logic [TAG_W-1:0]  in_tag;
  logic [TIME_W-1:0] in_now;

  assign in_cmd  = in_tuser[1:0];
  assign in_time = in_tdata[31:0];
  assign in_tag  = in_tdata[47:32];
  assign in_now  = in_tdata[79:48];

  // control and queue state
  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TIME_W-1:0] head_time_r, head_time_nxt;

  // per-command working registers
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [TIME_W-1:0] etime_r, etime_nxt;
  logic [TAG_W-1:0]  etag_r, etag_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              flush_r, flush_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;
  logic                   out_last_r;

  // store port
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  teq_entry_t  wr_data;
  logic [AW-1:0] rd_addr;
  teq_entry_t  rd_data;

  teq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared time unit: due test and wait for every result
  logic [TIME_W-1:0] cmp_time;
  logic              cmp_gt;
  logic [TIME_W-1:0] cmp_diff;

  assign cmp_time = (state_r == S_POP_EMIT) ? rd_data.due : head_time_r;
  assign cmp_gt   = cmp_time > now_r;
  assign cmp_diff = cmp_time - now_r;

  // result beat assembly
  logic              out_free;
  logic              emit;
  logic [CW-1:0]     res_count;
  logic              res_present;
  logic              pop_more;
  logic [CW+4:0]     res_count_ext;
  logic [TIME_W-1:0] res_wait;
  logic [TAG_W-1:0]  res_tag;
  logic              res_valid;
  logic              res_reason;
  logic [1:0]        res_status;
  logic              res_last;

  assign out_free = !out_valid_r || out_tready;
  assign emit     = out_free && ((state_r == S_RESULT) || (state_r == S_POP_EMIT));

  always_comb begin
    pop_more = 1'b0;
    if (state_r == S_POP_EMIT) begin
      res_count   = count_r - 1'b1;
      res_present = (count_r > CW'(1));
      res_tag     = tag_r;
      res_valid   = 1'b1;
      res_reason  = flush_r ? REASON_FLUSH : REASON_DUE;
      res_status  = ST_OK;
      pop_more    = res_present && (flush_r || !cmp_gt);
      res_last    = !pop_more;
    end else begin
      res_count   = count_r;
      res_present = (count_r != '0);
      res_tag     = '0;
      res_valid   = 1'b0;
      res_reason  = REASON_DUE;
      res_status  = status_r;
      res_last    = 1'b1;
    end
    res_wait      = (res_present && cmp_gt) ? cmp_diff : '0;
    res_count_ext = {5'd0, res_count};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    head_time_nxt = head_time_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    etime_nxt     = etime_r;
    etag_nxt      = etag_r;
    now_nxt       = now_r;
    status_nxt    = status_r;
    flush_nxt     = flush_r;
    tag_nxt       = tag_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = '{tag: etag_r, due: etime_r};
    rd_addr       = head_r;

    case (state_r)
      S_IDLE: begin
        rd_addr = (in_cmd == CMD_INSERT) ? ptr_dec(tail_r) : head_r;
        if (in_tvalid) begin
          etime_nxt  = in_time;
          etag_nxt   = in_tag;
          now_nxt    = in_now;
          status_nxt = ST_OK;
          flush_nxt  = (in_cmd == CMD_FLUSH);
          state_nxt  = S_RESULT;
          case (in_cmd)
            CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                // empty queue: the event becomes the head
                wr_en         = 1'b1;
                wr_addr       = tail_r;
                wr_data       = '{tag: in_tag, due: in_time};
                tail_nxt      = ptr_inc(tail_r);
                count_nxt     = count_r + 1'b1;
                head_time_nxt = in_time;
              end else begin
                ptr_nxt   = ptr_dec(tail_r);
                left_nxt  = count_r;
                state_nxt = S_INS_CMP;
              end
            end
            CMD_TICK: begin
              if ((count_r != '0) && (head_time_r <= in_now)) begin
                state_nxt = S_POP_TAG;
              end
            end
            CMD_FLUSH: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_POP_TAG;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_CMP: begin
        // walk down from the tail, shifting later entries up one slot
        rd_addr = ptr_dec(ptr_r);
        wr_en   = 1'b1;
        wr_addr = ptr_inc(ptr_r);
        if (rd_data.due > etime_r) begin
          wr_data = rd_data;
          if (left_r == CW'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            ptr_nxt  = ptr_dec(ptr_r);
            left_nxt = left_r - 1'b1;
          end
        end else begin
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + 1'b1;
          state_nxt = S_RESULT;
        end
      end

      S_INS_PUT: begin
        // every held entry was later: the event takes the head slot
        wr_en         = 1'b1;
        wr_addr       = ptr_r;
        tail_nxt      = ptr_inc(tail_r);
        count_nxt     = count_r + 1'b1;
        head_time_nxt = etime_r;
        state_nxt     = S_RESULT;
      end

      S_RESULT: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end

      S_POP_TAG: begin
        // head entry is on the read port; fetch the one behind it
        rd_addr   = ptr_inc(head_r);
        tag_nxt   = rd_data.tag;
        state_nxt = S_POP_EMIT;
      end

      S_POP_EMIT: begin
        rd_addr = ptr_inc(head_r);
        if (emit) begin
          head_nxt      = ptr_inc(head_r);
          count_nxt     = count_r - 1'b1;
          head_time_nxt = rd_data.due;
          state_nxt     = pop_more ? S_POP_TAG : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_time_r <= head_time_nxt;
    ptr_r       <= ptr_nxt;
    left_r      <= left_nxt;
    etime_r     <= etime_nxt;
    etag_r      <= etag_nxt;
    now_r       <= now_nxt;
    status_r    <= status_nxt;
    flush_r     <= flush_nxt;
    tag_r       <= tag_nxt;
    if (emit) begin
      out_data_r <= {2'b00, res_wait, res_present, res_count_ext[CNT_OUT_W-1:0], res_tag};
      out_user_r <= {res_status, res_reason, res_valid};
      out_last_r <= res_last;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/teq_checker.sv =====
// ----------------------------------------------------------------------------
// teq_checker - port-level checks for the timed event queue
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module teq_checker
  import teq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // one command at a time: no new beat taken right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in progress");

  // a beat without a released event carries a zero tag and a zero reason and ends its run
  a_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[15:0] == '0) && !out_tuser[1] && out_tlast)
    else $error("status beat carries release fields");

  // flush on an empty queue reports an empty queue
  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:2] == ST_EMPTY) |-> !out_tdata[21] && (out_tdata[53:22] == '0))
    else $error("empty flush shows a head event");

  // a rejected insert leaves a full, non-empty queue
  a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:2] == ST_FULL) |-> out_tdata[21])
    else $error("full status without a head event");

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);
